>>> rtl/core/nbody_pairwise_accel_core_defines.svh
// Assertion macros used by the checker module nbpa_chk of the pairwise acceleration core.
`ifndef NBODY_PAIRWISE_ACCEL_CORE_DEFINES_SVH
`define NBODY_PAIRWISE_ACCEL_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define NBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nbpa check failed");

// Next-cycle implication, ignored while reset is asserted.
`define NBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nbpa check failed");

// Next-cycle implication that also holds across reset.
`define NBPA_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nbpa check failed");

`endif

>>> rtl/core/nbpa_pkg.sv
package nbpa_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_EPS2 = 2'd0;
    localparam logic [1:0] REG_GRAV = 2'd1;
    localparam logic [1:0] REG_DAMP = 2'd2;

    localparam logic [31:0] EPS2_RST = 32'd2684355;
    localparam logic [31:0] GRAV_RST = 32'd16777216;
    localparam logic [16:0] DAMP_RST = 17'd65536;

    localparam int NUM_AXES  = 3;
    localparam int SQRT_BITS = 31;
    localparam int QUO_BITS  = 48;

    // Stage map
    localparam int ST_PROD     = 1;
    localparam int ST_R2       = 2;
    localparam int ST_SQRT0    = 3;
    localparam int ST_DEN_PART = ST_SQRT0 + SQRT_BITS;
    localparam int ST_DEN      = ST_DEN_PART + 1;
    localparam int ST_DIV0     = ST_DEN + 1;
    localparam int ST_SUM      = ST_DIV0 + QUO_BITS;
    localparam int ST_MUL      = ST_SUM + 1;
    localparam int ST_OUT      = ST_MUL + 1;
    localparam int NUM_STAGES  = ST_OUT + 1;

    // Payload carried down the pipeline
    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][31:0]  mag;
        logic [2:0][31:0]  accel;
        logic [2:0][63:0]  sq;
        logic [2:0][80:0]  num;
        logic [40:0]       r2;
        logic              r2z;
        logic [61:0]       rem;
        logic [30:0]       root;
        logic [62:0]       plo;
        logic [39:0]       phi;
        logic [71:0]       den;
        logic [2:0][71:0]  part;
        logic [2:0][47:0]  quo;
        logic [2:0]        big;
        logic [2:0][49:0]  sum;
        logic [2:0]        over;
        logic [2:0]        sneg;
        logic [2:0][42:0]  mhi;
        logic [2:0][40:0]  mlo;
        logic [2:0][31:0]  out;
        logic              sat;
    } t_stage;

endpackage

>>> rtl/core/nbody_pairwise_accel_core.sv
// Softened-gravity pairwise acceleration, fully pipelined over 87 register stages.
// Throughput: one pair per cycle while no result is held at the output; the square root takes
// one bit per stage (31 stages) and the division one quotient bit per stage (48 stages).
// Reset (synchronous, active low) clears all valid bits and restores register defaults.
module nbody_pairwise_accel_core import nbpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_source_x,
    input  logic signed [31:0] i_source_y,
    input  logic signed [31:0] i_source_z,
    input  logic signed [31:0] i_accel_in_x,
    input  logic signed [31:0] i_accel_in_y,
    input  logic signed [31:0] i_accel_in_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_accel_out_x,
    output logic signed [31:0] o_accel_out_y,
    output logic signed [31:0] o_accel_out_z,
    output logic               o_saturated
);

    logic [31:0] r_eps2;
    logic [31:0] r_grav;
    logic [16:0] r_damp;

    logic [NUM_STAGES-1:0] r_vld;
    t_stage                r_stg [NUM_STAGES];
    t_stage                n_stg [NUM_STAGES];
    logic                  w_en;

    logic [31:0] w_tgt [NUM_AXES];
    logic [31:0] w_src [NUM_AXES];
    logic [31:0] w_acc [NUM_AXES];

    assign w_tgt[0] = i_target_x;
    assign w_tgt[1] = i_target_y;
    assign w_tgt[2] = i_target_z;
    assign w_src[0] = i_source_x;
    assign w_src[1] = i_source_y;
    assign w_src[2] = i_source_z;
    assign w_acc[0] = i_accel_in_x;
    assign w_acc[1] = i_accel_in_y;
    assign w_acc[2] = i_accel_in_z;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps2 <= EPS2_RST;
            r_grav <= GRAV_RST;
            r_damp <= DAMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EPS2: r_eps2 <= i_cfg_data;
                REG_GRAV: r_grav <= i_cfg_data;
                REG_DAMP: r_damp <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output stage holds an untaken result
    assign w_en       = !r_vld[ST_OUT] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stg
        t_stage v_n;

        if (k == 0) begin : g_diff
            // Difference vector, split into sign and magnitude
            always_comb begin
                logic signed [32:0] v_d;
                v_n = '0;
                for (int a = 0; a < NUM_AXES; a++) begin
                    v_d = $signed({w_src[a][31], w_src[a]}) - $signed({w_tgt[a][31], w_tgt[a]});
                    v_n.neg[a]   = v_d[32];
                    v_n.mag[a]   = v_d[32] ? 32'(-v_d) : v_d[31:0];
                    v_n.accel[a] = w_acc[a];
                end
            end
        end else if (k == ST_PROD) begin : g_prod
            // Squares and gravity numerators
            always_comb begin
                logic [63:0] v_p;
                v_n = r_stg[k-1];
                for (int a = 0; a < NUM_AXES; a++) begin
                    v_n.sq[a]  = r_stg[k-1].mag[a] * r_stg[k-1].mag[a];
                    v_p        = r_stg[k-1].mag[a] * r_grav;
                    v_n.num[a] = {v_p, 17'd0};
                end
            end
        end else if (k == ST_R2) begin : g_r2
            // Softened squared distance; seed the root search
            always_comb begin
                v_n      = r_stg[k-1];
                v_n.r2   = 41'(r_eps2) + 41'(r_stg[k-1].sq[0][63:26])
                         + 41'(r_stg[k-1].sq[1][63:26]) + 41'(r_stg[k-1].sq[2][63:26]);
                v_n.r2z  = (v_n.r2 == '0);
                v_n.rem  = {1'b0, v_n.r2, 20'd0};
                v_n.root = '0;
            end
        end else if (k >= ST_SQRT0 && k < ST_DEN_PART) begin : g_sqrt
            localparam int B = SQRT_BITS - 1 - (k - ST_SQRT0);
            // Decide one root bit
            always_comb begin
                logic [61:0] v_t;
                v_n = r_stg[k-1];
                v_t = (62'(r_stg[k-1].root) << (B + 1)) + (62'(1) << (2 * B));
                if (r_stg[k-1].rem >= v_t) begin
                    v_n.rem     = r_stg[k-1].rem - v_t;
                    v_n.root[B] = 1'b1;
                end
            end
        end else if (k == ST_DEN_PART) begin : g_den_part
            // Partial products of r2 times the root
            always_comb begin
                v_n     = r_stg[k-1];
                v_n.plo = r_stg[k-1].r2[31:0] * r_stg[k-1].root;
                v_n.phi = r_stg[k-1].r2[40:32] * r_stg[k-1].root;
            end
        end else if (k == ST_DEN) begin : g_den
            // Denominator, overflow check and first partial remainder
            always_comb begin
                v_n     = r_stg[k-1];
                v_n.den = 72'(r_stg[k-1].plo) + {r_stg[k-1].phi, 32'd0};
                for (int a = 0; a < NUM_AXES; a++) begin
                    v_n.part[a] = 72'(r_stg[k-1].num[a][80:48]);
                    v_n.big[a]  = (72'(r_stg[k-1].num[a][80:48]) >= v_n.den);
                    v_n.quo[a]  = '0;
                end
            end
        end else if (k >= ST_DIV0 && k < ST_SUM) begin : g_div
            localparam int I = QUO_BITS - 1 - (k - ST_DIV0);
            // Decide one quotient bit per axis
            always_comb begin
                logic [72:0] v_t;
                v_n = r_stg[k-1];
                for (int a = 0; a < NUM_AXES; a++) begin
                    v_t = {r_stg[k-1].part[a], r_stg[k-1].num[a][I]};
                    if (v_t >= {1'b0, r_stg[k-1].den}) begin
                        v_t           = v_t - {1'b0, r_stg[k-1].den};
                        v_n.quo[a][I] = 1'b1;
                    end
                    v_n.part[a] = v_t[71:0];
                end
            end
        end else if (k == ST_SUM) begin : g_sum
            // Clamp the term and add it to the running acceleration
            always_comb begin
                logic [48:0] v_term;
                logic [49:0] v_acc;
                v_n = r_stg[k-1];
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (r_stg[k-1].r2z) begin
                        v_term = '0;
                    end else if (r_stg[k-1].big[a]) begin
                        v_term = 49'(1) << QUO_BITS;
                    end else begin
                        v_term = {1'b0, r_stg[k-1].quo[a]};
                    end
                    v_acc      = {{18{r_stg[k-1].accel[a][31]}}, r_stg[k-1].accel[a]};
                    v_n.sum[a] = r_stg[k-1].neg[a] ? v_acc - {1'b0, v_term}
                                                   : v_acc + {1'b0, v_term};
                end
            end
        end else if (k == ST_MUL) begin : g_mul
            // Range check and split damping product
            always_comb begin
                logic signed [49:0] v_s;
                logic signed [42:0] v_mh;
                v_n = r_stg[k-1];
                for (int a = 0; a < NUM_AXES; a++) begin
                    v_s         = $signed(r_stg[k-1].sum[a]);
                    v_n.over[a] = (v_s > 50'sd140737488355328) || (v_s < -50'sd140737488355328);
                    v_n.sneg[a] = v_s[49];
                    v_mh        = $signed(v_s[48:24]) * $signed({1'b0, r_damp});
                    v_n.mhi[a]  = v_mh;
                    v_n.mlo[a]  = v_s[23:0] * r_damp;
                end
            end
        end else begin : g_out
            // Combine partials, floor and clip
            always_comb begin
                logic signed [66:0] v_pr;
                logic signed [50:0] v_f;
                v_n     = r_stg[k-1];
                v_n.sat = 1'b0;
                for (int a = 0; a < NUM_AXES; a++) begin
                    v_pr = $signed({r_stg[k-1].mhi[a], 24'd0}) + $signed({1'b0, r_stg[k-1].mlo[a]});
                    v_f  = v_pr[66:16];
                    if (r_damp == '0) begin
                        v_n.out[a] = '0;
                    end else if (r_stg[k-1].over[a]) begin
                        v_n.out[a] = r_stg[k-1].sneg[a] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        v_n.sat    = 1'b1;
                    end else if (v_f > 51'sd2147483647) begin
                        v_n.out[a] = 32'h7FFF_FFFF;
                        v_n.sat    = 1'b1;
                    end else if (v_f < -51'sd2147483648) begin
                        v_n.out[a] = 32'h8000_0000;
                        v_n.sat    = 1'b1;
                    end else begin
                        v_n.out[a] = v_f[31:0];
                    end
                end
            end
        end

        assign n_stg[k] = v_n;
    end

    assign o_out_valid   = r_vld[ST_OUT];
    assign o_accel_out_x = r_stg[ST_OUT].out[0];
    assign o_accel_out_y = r_stg[ST_OUT].out[1];
    assign o_accel_out_z = r_stg[ST_OUT].out[2];
    assign o_saturated   = r_stg[ST_OUT].sat;

endmodule

>>> rtl/core/nbpa_chk.sv
`include "nbody_pairwise_accel_core_defines.svh"

module nbpa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_accel_out_x,
    input logic [31:0] o_accel_out_y,
    input logic [31:0] o_accel_out_z,
    input logic        o_saturated
);

    // Reset empties the pipeline
    `NBPA_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

    // A stalled result blocks new transfers
    `NBPA_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)

    // A stalled result stays put
    `NBPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_accel_out_x) && $stable(o_accel_out_y)
        && $stable(o_accel_out_z) && $stable(o_saturated))

    // A clipped result has at least one component on a rail
    `NBPA_ASSERT_NOW(a_sat_rail, i_clk, i_rst_n, o_out_valid && o_saturated,
        o_accel_out_x == 32'h7FFF_FFFF || o_accel_out_x == 32'h8000_0000
        || o_accel_out_y == 32'h7FFF_FFFF || o_accel_out_y == 32'h8000_0000
        || o_accel_out_z == 32'h7FFF_FFFF || o_accel_out_z == 32'h8000_0000)

endmodule

bind nbody_pairwise_accel_core nbpa_chk u_nbpa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_accel_out_x (o_accel_out_x),
    .o_accel_out_y (o_accel_out_y),
    .o_accel_out_z (o_accel_out_z),
    .o_saturated   (o_saturated)
);

>>> verif/nbody_pairwise_accel_checker.sv
module nbody_pairwise_accel_checker import nbpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_source_x,
    input  logic signed [31:0] i_source_y,
    input  logic signed [31:0] i_source_z,
    input  logic signed [31:0] i_accel_in_x,
    input  logic signed [31:0] i_accel_in_y,
    input  logic signed [31:0] i_accel_in_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_accel_out_x,
    input  logic signed [31:0] i_accel_out_y,
    input  logic signed [31:0] i_accel_out_z,
    input  logic               i_saturated,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count,
    output int                 o_sat_count
);

    typedef struct packed {
        logic [2:0][31:0] acc;
        logic             sat;
    } t_accel_result;

    logic [31:0] eps2_q;
    logic [31:0] grav_q;
    logic [16:0] damp_q;
    t_accel_result accel_q[$];

    // Per-axis term: |d|*g*2^17 / (r2*s), truncated, clamped at 2^48
    function automatic logic signed [63:0] pair_term(logic signed [32:0] d,
                                                     logic [40:0] r2, logic [63:0] s);
        logic [32:0]  mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        mag = d < 0 ? 33'(-d) : 33'(d);
        if (r2 == 0 || mag == 0) return 0;
        num = ({95'd0, mag} * {96'd0, grav_q}) << 17;
        den = {87'd0, r2} * {64'd0, s};
        quo = num / den;
        if (quo >= (128'd1 << 48)) quo = 128'd1 << 48;
        return d < 0 ? -$signed(64'(quo)) : $signed(64'(quo));
    endfunction

    // Damp with floor, then saturate to Q16.16
    function automatic logic [31:0] damp_clip(logic signed [63:0] sum, ref logic sat);
        logic signed [127:0] p;
        logic signed [127:0] r;
        if (damp_q == 0 || sum == 0) return 0;
        p = 128'(sum) * $signed({111'd0, damp_q});
        r = p >>> 16;
        if (r > 128'sh7FFFFFFF) begin
            sat = 1;
            return 32'h7FFFFFFF;
        end
        if (r < -128'sh80000000) begin
            sat = 1;
            return 32'h80000000;
        end
        return r[31:0];
    endfunction

    function automatic t_accel_result predict_accel(logic [2:0][31:0] tgt,
                                                    logic [2:0][31:0] src,
                                                    logic [2:0][31:0] ain);
        t_accel_result res;
        logic signed [32:0] d[3];
        logic [65:0]  m2;
        logic [63:0]  r2;
        logic [63:0]  v;
        logic [63:0]  s;
        logic [63:0]  bitv;
        logic         sat;
        r2 = eps2_q;
        sat = 0;
        for (int k = 0; k < NUM_AXES; k++) begin
            d[k] = $signed({src[k][31], src[k]}) - $signed({tgt[k][31], tgt[k]});
            m2 = d[k] < 0 ? 66'(-d[k]) : 66'(d[k]);
            m2 = m2 * m2;
            r2 += 64'(m2 >> 26);
        end
        // integer square root of r2 * 2^20
        v = r2 << 20;
        s = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= s + bitv) begin
                v -= s + bitv;
                s = (s >> 1) + bitv;
            end else begin
                s >>= 1;
            end
            bitv >>= 2;
        end
        for (int k = 0; k < NUM_AXES; k++)
            res.acc[k] = damp_clip($signed({{32{ain[k][31]}}, ain[k]}) +
                                   pair_term(d[k], r2[40:0], s), sat);
        res.sat = sat;
        return res;
    endfunction

    // Track config writes, enqueue on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_accel_result got;
        t_accel_result exp_r;
        if (!i_rst_n) begin
            eps2_q = EPS2_RST;
            grav_q = GRAV_RST;
            damp_q = DAMP_RST;
            accel_q.delete();
            o_fail_count = 0;
            o_result_count = 0;
            o_sat_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_EPS2: eps2_q = i_cfg_data;
                    REG_GRAV: grav_q = i_cfg_data;
                    REG_DAMP: damp_q = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.acc = {i_accel_out_z, i_accel_out_y, i_accel_out_x};
                got.sat = i_saturated;
                o_result_count++;
                if (got.sat) o_sat_count++;
                if (accel_q.size() == 0) begin
                    $error("result transfer with no pending pair");
                    o_fail_count++;
                end else begin
                    exp_r = accel_q.pop_front();
                    for (int k = 0; k < NUM_AXES; k++)
                        if (got.acc[k] !== exp_r.acc[k]) begin
                            $error("accel_out_%s: expected %0d got %0d", k == 0 ? "x" :
                                   k == 1 ? "y" : "z", $signed(exp_r.acc[k]),
                                   $signed(got.acc[k]));
                            o_fail_count++;
                        end
                    if (got.sat !== exp_r.sat) begin
                        $error("saturated: expected %0d got %0d", exp_r.sat, got.sat);
                        o_fail_count++;
                    end
                end
            end
            // Append the prediction at the tail
            if (i_in_valid && i_in_ready)
                accel_q = {accel_q, predict_accel({i_target_z, i_target_y, i_target_x},
                                                  {i_source_z, i_source_y, i_source_x},
                                                  {i_accel_in_z, i_accel_in_y,
                                                   i_accel_in_x})};
        end
        o_pending = accel_q.size();
    end

endmodule

>>> verif/tb_nbody_pairwise_accel_core.sv
module tb_nbody_pairwise_accel_core;
    import nbpa_pkg::*;

    localparam int LATENCY   = 87;
    localparam int MAX_CYCLE = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic signed [31:0] pos_t[3];
    logic signed [31:0] pos_s[3];
    logic signed [31:0] acc_in[3];
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [31:0] acc_out_x, acc_out_y, acc_out_z;
    logic        sat;
    int          fail_count, pending, result_count, sat_count;
    int          cycle;
    int          send_idle_pct, recv_idle_pct;
    int          pair_count;

    nbody_pairwise_accel_core u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_target_x(pos_t[0]), .i_target_y(pos_t[1]), .i_target_z(pos_t[2]),
        .i_source_x(pos_s[0]), .i_source_y(pos_s[1]), .i_source_z(pos_s[2]),
        .i_accel_in_x(acc_in[0]), .i_accel_in_y(acc_in[1]), .i_accel_in_z(acc_in[2]),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_accel_out_x(acc_out_x), .o_accel_out_y(acc_out_y),
        .o_accel_out_z(acc_out_z), .o_saturated(sat)
    );

    nbody_pairwise_accel_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_target_x(pos_t[0]), .i_target_y(pos_t[1]), .i_target_z(pos_t[2]),
        .i_source_x(pos_s[0]), .i_source_y(pos_s[1]), .i_source_z(pos_s[2]),
        .i_accel_in_x(acc_in[0]), .i_accel_in_y(acc_in[1]), .i_accel_in_z(acc_in[2]),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_accel_out_x(acc_out_x), .i_accel_out_y(acc_out_y),
        .i_accel_out_z(acc_out_z), .i_saturated(sat),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_sat_count(sat_count)
    );

    // Clock
    initial clk = 0;
    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // Cycle limit
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("tb_nbody_pairwise_accel_core: done, errors");
            $finish;
        end
    end

    // Receiver stall, decided at each falling edge
    always @(negedge clk) begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom();
            3: return 0;
            default: return $signed($urandom_range(32'h01FFFFFF)) - 32'sh00FFFFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_acc();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $signed($urandom_range(32'h0003FFFF)) - 32'sh0001FFFF;
        endcase
    endfunction

    // Offer one pair and hold it until transfer; valid drops only when idling
    task automatic send_pair(logic [31:0] tx, ty, tz, sx, sy, sz, ax, ay, az);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        pos_t[0] <= tx; pos_t[1] <= ty; pos_t[2] <= tz;
        pos_s[0] <= sx; pos_s[1] <= sy; pos_s[2] <= sz;
        acc_in[0] <= ax; acc_in[1] <= ay; acc_in[2] <= az;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        pair_count++;
    endtask

    task automatic send_random(int n);
        logic [31:0] tx;
        logic [31:0] ty;
        logic [31:0] tz;
        repeat (n) begin
            tx = pick_pos(); ty = pick_pos(); tz = pick_pos();
            if ($urandom_range(4) == 0)
                send_pair(tx, ty, tz, tx, ty, tz, pick_acc(), pick_acc(), pick_acc());
            else
                send_pair(tx, ty, tz, pick_pos(), pick_pos(), pick_pos(),
                          pick_acc(), pick_acc(), pick_acc());
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // Drive one write for a cycle; the caller drops the enable
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic write_all(logic [31:0] eps2, logic [31:0] grav, logic [31:0] damp);
        write_reg(REG_EPS2, eps2);
        write_reg(REG_GRAV, grav);
        write_reg(REG_DAMP, damp);
        cfg_we <= 0;
    endtask

    initial begin
        rst_n = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0; in_valid = 0;
        pair_count = 0;
        send_idle_pct = 31; recv_idle_pct = 70;
        for (int k = 0; k < 3; k++) begin
            pos_t[k] = 0; pos_s[k] = 0; acc_in[k] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: extremes, zero distance, huge term, saturation
        send_pair(0, 0, 0, 32'h08000000, 0, 0, 0, 0, 0);
        send_pair(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 0);
        send_pair(32'h7FFFFFFF, 0, 32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF,
                  32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_pair(5, 5, 5, 6, 5, 4, 32'h7FFFFFFF, 32'h80000000, 1);
        send_pair(100, 200, 300, 100, 200, 300, 32'h12345678, 32'hEDCBA988, 0);
        drain();
        write_all(0, 32'hFFFFFFFF, 32'h1FFFF);
        // zero distance with zero softening, then tiny distances for huge terms
        send_pair(1, 2, 3, 1, 2, 3, 32'h7FFFFFFF, 32'h80000000, 7);
        send_pair(0, 0, 0, 1, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 0);
        send_pair(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h40000000, 32'hC0000000, 32'h7FFFFFFF);
        send_random(10);
        drain();
        // zero damping; index beyond the list; oversized damping value
        write_all(32'hFFFFFFFF, 0, 32'hFFFE0000);
        write_reg(2'd3, 32'hDEADBEEF);
        cfg_we <= 0;
        send_pair(0, 0, 0, 1, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h1234);
        send_random(8);

        // Random phases across settings and idling profiles
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: write_all(EPS2_RST, GRAV_RST, DAMP_RST);
                1: write_all($urandom(), $urandom(), $urandom_range(32'h1FFFF));
                2: write_all(32'd1, 32'h00010000, 32'h0000FFFF);
                3: write_all($urandom_range(32'h00FFFFFF), $urandom(), 32'h00010000);
                4: write_all($urandom(), 32'hFFFFFFFF, 32'h00018000);
                default: write_all(EPS2_RST, $urandom(), $urandom_range(32'h1FFFF));
            endcase
            if (ph == 2) begin
                send_idle_pct = 70; recv_idle_pct = 31;
            end else if (ph == 4) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            send_random(285);
        end

        drain();
        $display("Sent %0d pairs over 9 register settings; %0d results, %0d saturated.",
                 pair_count, result_count, sat_count);
        if (fail_count == 0 && pending == 0)
            $display("tb_nbody_pairwise_accel_core: done, clean");
        else
            $display("tb_nbody_pairwise_accel_core: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/nbpa_pkg.sv
rtl/core/nbody_pairwise_accel_core.sv
rtl/core/nbpa_chk.sv
verif/nbody_pairwise_accel_checker.sv
verif/tb_nbody_pairwise_accel_core.sv
